@@ rtl/baro_pkg.sv @@
`default_nettype none
package baro_pkg;

    typedef struct packed {
        logic        mode;
        logic [19:0] raw_adc;
    } baro_in_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] temp_millic;
        logic [31:0] pressure_pa;
        logic        divide_fault;
    } baro_out_t;

    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        REG_TRIM_TEMP = 2'd0,
        REG_TRIM_PA   = 2'd1,
        REG_TRIM_PB   = 2'd2,
        REG_TRIM_PC   = 2'd3
    } baro_reg_t;

endpackage
`default_nettype wire

@@ rtl/baro_integer_compensation.sv @@
// temperature: T0 to T5; pressure: P0 to P9, divider, Q0 to Q3; a zero divisor ends at P9
// flow: one request in flight; the next is taken the cycle after its result
// moves to the output register
// a waiting result holds the block in the done step; no new request is taken meanwhile
// cost: one shared 32x32 multiplier, at most one product per step, and a restoring divider
// reset: rst_n clears the trim registers, the fine temperature and all control state
`default_nettype none
module baro_integer_compensation (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  baro_pkg::baro_in_t                 in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output baro_pkg::baro_out_t                out_data,
    input  wire logic                          cfg_we,
    input  wire logic [baro_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [baro_pkg::CFG_W-1:0]    cfg_wdata
);
    import baro_pkg::*;

    // arithmetic shift right of a 32-bit two's complement word
    function automatic logic [31:0] sar32(input logic [31:0] x, input logic [4:0] n);
        return $signed(x) >>> n;
    endfunction

    // sequencer steps; each step does at most one multiply
    typedef enum logic [4:0] {
        S_IDLE, S_T0, S_T1, S_T2, S_T3, S_T4, S_T5,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
        S_DIV, S_DEND, S_Q0, S_Q1, S_Q2, S_Q3, S_DONE
    } state_t;

    state_t      state_reg;
    logic [47:0] trim_t_reg;
    logic [63:0] trim_a_reg;
    logic [63:0] trim_b_reg;
    logic [15:0] trim_c_reg;
    logic [31:0] fine_reg;
    logic [19:0] adc_reg;
    logic [31:0] r0_reg, r1_reg, r2_reg, r3_reg;
    logic [31:0] prod_reg;
    // divider state
    logic [31:0] quo_reg, rem_reg, dvs_reg;
    logic [5:0]  cnt_reg;
    logic        dbl_reg;
    logic        busy_reg;
    baro_out_t   res_reg;
    baro_out_t   out_reg;
    logic        out_valid_reg;

    // trim words widened to 32 bits: t1 and p1 zero-extended, the others sign-extended
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, trim_t_reg[15:0]};
    assign t2 = {{16{trim_t_reg[31]}}, trim_t_reg[31:16]};
    assign t3 = {{16{trim_t_reg[47]}}, trim_t_reg[47:32]};
    assign p1 = {16'd0, trim_a_reg[15:0]};
    assign p2 = {{16{trim_a_reg[31]}}, trim_a_reg[31:16]};
    assign p3 = {{16{trim_a_reg[47]}}, trim_a_reg[47:32]};
    assign p4 = {{16{trim_a_reg[63]}}, trim_a_reg[63:48]};
    assign p5 = {{16{trim_b_reg[15]}}, trim_b_reg[15:0]};
    assign p6 = {{16{trim_b_reg[31]}}, trim_b_reg[31:16]};
    assign p7 = {{16{trim_b_reg[47]}}, trim_b_reg[47:32]};
    assign p8 = {{16{trim_b_reg[63]}}, trim_b_reg[63:48]};
    assign p9 = {{16{trim_c_reg[15]}}, trim_c_reg[15:0]};

    // the one shared multiplier, low 32 bits of the product
    logic [31:0] mul_a, mul_b, mul_y;
    assign mul_y = mul_a * mul_b;

    logic [31:0] adc32;
    assign adc32 = {12'd0, adc_reg};

    // operand selection per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_T0: begin mul_a = (adc32 >> 3) - (t1 << 1); mul_b = t2; end
            S_T1: begin mul_a = (adc32 >> 4) - t1; mul_b = (adc32 >> 4) - t1; end
            S_T2: begin mul_a = sar32(prod_reg, 5'd12); mul_b = t3; end
            S_T4: begin mul_a = r0_reg; mul_b = 32'd50; end
            S_P0: begin mul_a = sar32(r0_reg, 5'd2); mul_b = sar32(r0_reg, 5'd2); end
            S_P1: begin mul_a = sar32(prod_reg, 5'd11); mul_b = p6; end
            S_P2: begin mul_a = r0_reg; mul_b = p5; end
            S_P3: begin mul_a = p3; mul_b = sar32(r1_reg, 5'd13); end
            S_P4: begin mul_a = p2; mul_b = r0_reg; end
            S_P6: begin mul_a = 32'd32768 + r3_reg; mul_b = p1; end
            S_P7: begin mul_a = r2_reg; mul_b = 32'd3125; end
            S_Q0: begin mul_a = quo_reg >> 3; mul_b = quo_reg >> 3; end
            S_Q1: begin mul_a = p9; mul_b = prod_reg >> 13; end
            S_Q2: begin mul_a = quo_reg >> 2; mul_b = p8; end
            default: ;
        endcase
    end

    // divider step: shift in one dividend bit
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    assign rem_sh  = {rem_reg, quo_reg[31]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    // the finished result moves to the output register once that register is free
    logic done_go;
    assign done_go = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign in_ready = !busy_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            trim_t_reg    <= '0;
            trim_a_reg    <= '0;
            trim_b_reg    <= '0;
            trim_c_reg    <= '0;
            fine_reg      <= '0;
            adc_reg       <= '0;
            r0_reg        <= '0;
            r1_reg        <= '0;
            r2_reg        <= '0;
            r3_reg        <= '0;
            prod_reg      <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            dvs_reg       <= '0;
            cnt_reg       <= '0;
            dbl_reg       <= 1'b0;
            res_reg       <= '0;
            out_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (baro_reg_t'(cfg_index))
                    REG_TRIM_TEMP: trim_t_reg <= cfg_wdata[47:0];
                    REG_TRIM_PA:   trim_a_reg <= cfg_wdata;
                    REG_TRIM_PB:   trim_b_reg <= cfg_wdata;
                    REG_TRIM_PC:   trim_c_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (done_go)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            prod_reg <= mul_y;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        adc_reg  <= in_data.raw_adc;
                        busy_reg <= 1'b1;
                        // pressure starts from v1 = (fine >> 1) - 64000
                        r0_reg   <= sar32(fine_reg, 5'd1) - 32'd64000;
                        state_reg <= in_data.mode ? S_P0 : S_T0;
                    end
                end
                // temperature path
                S_T0: state_reg <= S_T1;
                S_T1:
                begin
                    r1_reg    <= sar32(prod_reg, 5'd11);
                    state_reg <= S_T2;
                end
                S_T2: state_reg <= S_T3;
                S_T3:
                begin
                    r0_reg    <= r1_reg + sar32(prod_reg, 5'd14);
                    fine_reg  <= r1_reg + sar32(prod_reg, 5'd14);
                    state_reg <= S_T4;
                end
                S_T4: state_reg <= S_T5;
                S_T5:
                begin
                    res_reg.kind         <= 1'b0;
                    res_reg.temp_millic  <= sar32(prod_reg + 32'd1280, 5'd8);
                    res_reg.pressure_pa  <= '0;
                    res_reg.divide_fault <= 1'b0;
                    state_reg <= S_DONE;
                end
                // pressure path
                S_P0: state_reg <= S_P1;
                S_P1:
                begin
                    r1_reg    <= prod_reg;   // q
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    r2_reg    <= prod_reg;   // q>>11 * p6
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    // v2 = (v2 + (v1*p5 << 1)) >> 2 + (p4 << 16)
                    r2_reg    <= sar32(r2_reg + (prod_reg << 1), 5'd2) + (p4 << 16);
                    state_reg <= S_P4;
                end
                S_P4:
                begin
                    r3_reg    <= sar32(prod_reg, 5'd3);
                    state_reg <= S_P5;
                end
                S_P5:
                begin
                    r3_reg    <= sar32(r3_reg + sar32(prod_reg, 5'd1), 5'd18);
                    r2_reg    <= (32'd1048576 - adc32) - sar32(r2_reg, 5'd12);
                    state_reg <= S_P6;
                end
                S_P6: state_reg <= S_P7;
                S_P7:
                begin
                    dvs_reg   <= sar32(prod_reg, 5'd15);
                    state_reg <= S_P8;
                end
                S_P8:
                begin
                    r2_reg    <= prod_reg;   // p * 3125
                    state_reg <= S_P9;
                end
                S_P9:
                begin
                    if (dvs_reg == 32'd0)
                    begin
                        res_reg.kind         <= 1'b1;
                        res_reg.temp_millic  <= '0;
                        res_reg.pressure_pa  <= '0;
                        res_reg.divide_fault <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        dbl_reg   <= r2_reg[31];
                        quo_reg   <= r2_reg[31] ? r2_reg : (r2_reg << 1);
                        rem_reg   <= '0;
                        cnt_reg   <= 6'd32;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (!rem_sub[32])
                    begin
                        rem_reg <= rem_sub[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                        state_reg <= S_DEND;
                end
                S_DEND:
                begin
                    if (dbl_reg)
                        quo_reg <= quo_reg << 1;
                    state_reg <= S_Q0;
                end
                S_Q0: state_reg <= S_Q1;
                S_Q1: state_reg <= S_Q2;
                S_Q2:
                begin
                    r1_reg    <= sar32(prod_reg, 5'd12);   // v1
                    state_reg <= S_Q3;
                end
                S_Q3:
                begin
                    res_reg.kind         <= 1'b1;
                    res_reg.temp_millic  <= '0;
                    res_reg.pressure_pa  <= quo_reg + sar32(r1_reg
                                            + sar32(prod_reg, 5'd13) + p7, 5'd4);
                    res_reg.divide_fault <= 1'b0;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // wait here while an earlier result is still offered
                    if (done_go)
                    begin
                        out_reg   <= res_reg;
                        busy_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // a waiting result stays offered and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting result dropped or changed");
    // a fault result carries zero pressure
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.divide_fault) |-> (out_reg.pressure_pa == 32'd0))
        else $error("fault with nonzero pressure");
    // accepting a request makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> busy_reg)
        else $error("request not started");

endmodule
`default_nettype wire
